### rtl/ukst_pkg.sv
// Package for the unique key set table: sizes, request codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package ukst_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } ukst_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } ukst_state_e;

  typedef struct packed {
    logic load_key;     // latch the request key, restart walk at entry 0
    logic shift_start;  // restart walk just above the hit entry
    logic walk;         // read current entry, advance walk index
    logic shift_wr;     // write each returned entry one place lower
    logic ins_wr;       // append key at the end, raise count
    logic dec_count;
    logic clr_count;
    logic finish;       // register a result for one cycle
    logic res_success;
    logic res_pos_hit;  // report the hit index as position
  } ukst_cmd_t;

  typedef struct packed {
    logic hit;
    logic walk_done;
    logic full;
  } ukst_sts_t;

endpackage

### rtl/ukst_ctrl.sv
// Controller for the unique key set table: request decode and sequencing of
// scan, shift-down and result. Depends on ukst_pkg.
module ukst_ctrl import ukst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic [1:0] req_type_i,
  output logic      busy,
  input  ukst_sts_t sts_i,
  output ukst_cmd_t cmd_o
);

  ukst_state_e state_q, state_d;
  ukst_req_e   op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= REQ_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d = ukst_req_e'(req_type_i);
          if (ukst_req_e'(req_type_i) != REQ_CLEAR) state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = (op_q == REQ_REMOVE) ? ST_SHIFT : ST_IDLE;
        end else if (sts_i.walk_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (sts_i.walk_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (ukst_req_e'(req_type_i) == REQ_CLEAR) begin
            cmd_o.clr_count   = 1'b1;
            cmd_o.finish      = 1'b1;
            cmd_o.res_success = 1'b1;
          end else begin
            cmd_o.load_key = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          unique case (op_q)
            REQ_REMOVE: cmd_o.shift_start = 1'b1;
            REQ_SEARCH: begin
              cmd_o.finish      = 1'b1;
              cmd_o.res_success = 1'b1;
              cmd_o.res_pos_hit = 1'b1;
            end
            default: cmd_o.finish = 1'b1;  // duplicate insert
          endcase
        end else if (sts_i.walk_done) begin
          cmd_o.finish = 1'b1;
          if (op_q == REQ_INSERT && !sts_i.full) begin
            cmd_o.ins_wr      = 1'b1;
            cmd_o.res_success = 1'b1;
          end
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.dec_count   = 1'b1;
          cmd_o.finish      = 1'b1;
          cmd_o.res_success = 1'b1;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/ukst_dpath.sv
// Datapath for the unique key set table: entry memory with registered read,
// walk index, key compare, entry count and result registers. Depends on ukst_pkg.
module ukst_dpath import ukst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  ukst_cmd_t            cmd_i,
  output ukst_sts_t            sts_o,
  output logic                 result_valid_o,
  output logic                 success_o,
  output logic [IDX_W-1:0]     position_o,
  output logic [CNT_W-1:0]     count_o
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] rdata_q;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rvalid_q, rvalid_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 strobe_q;
  logic                 success_q;
  logic [IDX_W-1:0]     pos_q;
  logic                 in_range;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  assign in_range = (idx_q < count_q);

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.load_key) begin
      idx_d = '0;
    end else if (cmd_i.shift_start) begin
      idx_d = CNT_W'(rd_idx_q) + CNT_W'(1);
    end else if (cmd_i.walk && in_range) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  assign rvalid_d = cmd_i.walk && in_range;

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.clr_count) begin
      count_d = '0;
    end else if (cmd_i.ins_wr) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // append at the end, or move a returned entry one place down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = key_q;
    if (cmd_i.ins_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_wr && rvalid_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q - IDX_W'(1);
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q  <= mem[idx_q[IDX_W-1:0]];
    rd_idx_q <= idx_q[IDX_W-1:0];
    if (cmd_i.load_key) key_q <= key_i;
    if (cmd_i.finish) begin
      success_q <= cmd_i.res_success;
      pos_q     <= cmd_i.res_pos_hit ? rd_idx_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rvalid_q <= 1'b0;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      rvalid_q <= rvalid_d;
      count_q  <= count_d;
      strobe_q <= cmd_i.finish;
    end
  end

  assign sts_o.hit       = rvalid_q && (rdata_q == key_q);
  assign sts_o.walk_done = !rvalid_q && !in_range;
  assign sts_o.full      = (count_q == CNT_W'(CAPACITY));

  assign result_valid_o = strobe_q;
  assign success_o      = success_q;
  assign position_o     = pos_q;
  assign count_o        = count_q;

endmodule

### rtl/unique_key_set_table_unit.sv
// Top level of the unique key set table: joins controller and datapath.
// Depends on ukst_pkg, ukst_ctrl, ukst_dpath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  request  | start & !busy           | req_type_i[1:0], key_i[31:0]
//  result   | result_valid_o (1 cyc)  | success_o, position_o[5:0], count_o[6:0]
//
// Clear finishes in the accepting cycle; the result shows in the next. Insert,
// search and remove scan the stored entries one per cycle through the memory
// read port; the scan stops at the first hit, or when the entries run out on
// a miss. Remove then walks the entries above the hit down one place.
// Reset empties the table at once; entry contents need no clearing. The result
// strobe lasts one cycle and cannot be held; busy is low during it.
module unique_key_set_table_unit import ukst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  output logic                 result_valid_o,
  output logic                 success_o,
  output logic [IDX_W-1:0]     position_o,
  output logic [CNT_W-1:0]     count_o
);

  ukst_cmd_t cmd;
  ukst_sts_t sts;

  ukst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .busy       (busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ukst_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (key_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .success_o      (success_o),
    .position_o     (position_o),
    .count_o        (count_o)
  );

endmodule
